/* design/ppi_pkg.sv */
`timescale 1ns / 1ps
package ppi_pkg;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_SQRT = 7'b0000100,
    S_WALK = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_LERP = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic        [31:0] path_d;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } point_t;

  localparam logic [1:0]  OP_APPEND      = 2'd0;
  localparam logic [1:0]  OP_APPEND_DIST = 2'd1;
  localparam logic [1:0]  OP_INTERP      = 2'd2;
  localparam logic [16:0] RATIO_ONE      = 17'd65536;
  localparam int          OUT_W          = 136;
  localparam int          IN_W           = 152;

  function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    abs_diff = d[32] ? 32'(-d) : d[31:0];
  endfunction

endpackage

/* design/ppi_isqrt.sv */
`timescale 1ns / 1ps
module ppi_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [35:0] rem_sh, trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r, rad_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_nxt  = 34'(rem_sh - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[33:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      rad_nxt  = {rad_r[61:0], 2'b00};
      step_nxt = step_r + 5'd1;
      if (step_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* design/ppi_div.sv */
`timescale 1ns / 1ps
module ppi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [31:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [32:0] rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    rem_sh   = {rem_r, 1'b0};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = 32'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      step_nxt = step_r + 4'd1;
      if (step_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* design/polyline_path_interpolator.sv */
`timescale 1ns / 1ps
// Channel  Ports                              Word
// in       in_tvalid/in_tready/in_tdata/tuser one command with point, distance, fraction
// out      out_tvalid/out_tready/out_tdata    one result per command
// cfg      cfg_valid/cfg_ready/cfg_index/data start position registers
//
// From one accepted word to the next: an append with given distance, a dropped append or a word
// without a walk goes straight to the result state; an append with measured distance waits on
// the 32-step square root; an interpolation waits on the one-point-per-cycle walk up to its
// target point and on the 16-step divider, or on the walk alone when it needs no divide.
// Reset is synchronous and needs no clearing pass. A stalled output holds the finished
// result; the next word is taken while it waits, and its result then holds off the input.
module polyline_path_interpolator
  import ppi_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // in_x, in_y, in_z, in_dist, factor, zero fill
  input  logic [IN_W-1:0]    in_tdata,
  // opcode
  input  logic [1:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // out_x, out_y, out_z, total_dist, point_count, full_flag
  output logic [OUT_W-1:0]   out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [31:0] start_r [3];
  logic signed [31:0] last_r [3], last_nxt [3];
  logic [31:0] last_d_r, last_d_nxt;
  logic signed [31:0] p_r [3], p_nxt [3];
  logic [31:0] dx_r [3], dx_nxt [3];
  logic [1:0] ax_r, ax_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic sat_r, sat_nxt, sq_go_r, sq_go_nxt, dv_go_r, dv_go_nxt;
  logic [31:0] target_r, target_nxt, prev_d_r, prev_d_nxt;
  logic [31:0] num_r, num_nxt, den_r, den_nxt;
  logic [IW-1:0] idx_r, idx_nxt, rd_addr;
  logic signed [31:0] q_r [3], q_nxt [3], c_r [3], c_nxt [3];
  logic signed [31:0] res_r [3], res_nxt [3];
  logic [16:0] ratio_r, ratio_nxt;
  logic use_res_r, use_res_nxt, full_r, full_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  point_t mem [MAX_POINTS];
  point_t rd_q, wd;
  logic mem_we;

  logic sq_done, dv_done;
  logic [31:0] sq_root;
  logic [15:0] dv_quo;

  logic signed [31:0] in_p [3];
  logic [31:0] in_dist;
  logic signed [17:0] factor;
  logic [16:0] f_cl;
  logic [48:0] tgt_prod;
  logic signed [31:0] base [3];
  logic [31:0] base_d, seg, out_total;
  logic [63:0] sq;
  logic [64:0] sum_ext;
  logic [32:0] d_ext;
  logic signed [32:0] l_diff;
  logic signed [50:0] l_prod;
  logic [CW+6:0] cnt_ext;
  logic signed [31:0] o_p [3];

  ppi_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_go_r), .radicand(sum_r),
    .done(sq_done), .root(sq_root)
  );

  ppi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_go_r), .num(num_r), .den(den_r),
    .done(dv_done), .quo(dv_quo)
  );

  assign in_p[0] = in_tdata[31:0];
  assign in_p[1] = in_tdata[63:32];
  assign in_p[2] = in_tdata[95:64];
  assign in_dist = in_tdata[127:96];
  assign factor  = in_tdata[145:128];

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base[i] = (cnt_r == '0) ? start_r[i] : last_r[i];
    end
    base_d = (cnt_r == '0) ? 32'd0 : last_d_r;
    if (factor[17]) begin
      f_cl = '0;
    end else if (factor[16:0] > RATIO_ONE) begin
      f_cl = RATIO_ONE;
    end else begin
      f_cl = factor[16:0];
    end
    tgt_prod = 49'(last_d_r) * 49'(f_cl);
    sq       = 64'(dx_r[ax_r]) * 64'(dx_r[ax_r]);
    sum_ext  = {1'b0, sum_r} + {1'b0, sq};
    seg      = sat_r ? 32'hFFFF_FFFF : sq_root;
    d_ext    = {1'b0, base_d} + {1'b0, seg};
    l_diff   = {c_r[ax_r][31], c_r[ax_r]} - {q_r[ax_r][31], q_r[ax_r]};
    l_prod   = 51'(l_diff) * 51'(signed'({1'b0, ratio_r}));
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    last_d_nxt    = last_d_r;
    p_nxt         = p_r;
    dx_nxt        = dx_r;
    ax_nxt        = ax_r;
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    sq_go_nxt     = 1'b0;
    dv_go_nxt     = 1'b0;
    target_nxt    = target_r;
    prev_d_nxt    = prev_d_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    idx_nxt       = idx_r;
    rd_addr       = idx_r;
    q_nxt         = q_r;
    c_nxt         = c_r;
    res_nxt       = res_r;
    ratio_nxt     = ratio_r;
    use_res_nxt   = use_res_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    wd            = '{path_d: '0, z: p_r[2], y: p_r[1], x: p_r[0]};
    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_tvalid) begin
          p_nxt       = in_p;
          use_res_nxt = 1'b0;
          full_nxt    = 1'b0;
          state_nxt   = S_DONE;
          if (in_tuser == OP_APPEND || in_tuser == OP_APPEND_DIST) begin
            if (cnt_r >= CW'(MAX_POINTS)) begin
              full_nxt = 1'b1;
            end else if (in_tuser == OP_APPEND_DIST) begin
              mem_we     = 1'b1;
              wd         = '{path_d: in_dist, z: in_p[2], y: in_p[1], x: in_p[0]};
              last_nxt   = in_p;
              last_d_nxt = in_dist;
              cnt_nxt    = cnt_r + 1'b1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                dx_nxt[i] = abs_diff(base[i], in_p[i]);
              end
              ax_nxt    = '0;
              sum_nxt   = '0;
              sat_nxt   = 1'b0;
              state_nxt = S_MUL;
            end
          end else if (in_tuser == OP_INTERP && cnt_r != '0) begin
            target_nxt = tgt_prod[47:16];
            prev_d_nxt = '0;
            q_nxt      = start_r;
            idx_nxt    = '0;
            state_nxt  = S_WALK;
          end
        end
      end
      S_MUL: begin
        sum_nxt = sum_ext[63:0];
        if (sum_ext[64]) begin
          sat_nxt = 1'b1;
        end
        ax_nxt = ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          sq_go_nxt = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          mem_we     = 1'b1;
          wd.path_d  = d_ext[32] ? 32'hFFFF_FFFF : d_ext[31:0];
          last_nxt   = p_r;
          last_d_nxt = wd.path_d;
          cnt_nxt    = cnt_r + 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_WALK: begin
        if (target_r <= rd_q.path_d) begin
          c_nxt[0]  = rd_q.x;
          c_nxt[1]  = rd_q.y;
          c_nxt[2]  = rd_q.z;
          num_nxt   = target_r - prev_d_r;
          den_nxt   = rd_q.path_d - prev_d_r;
          ax_nxt    = '0;
          if (rd_q.path_d <= prev_d_r || target_r == prev_d_r) begin
            ratio_nxt = '0;
            state_nxt = S_LERP;
          end else if ((target_r - prev_d_r) >= (rd_q.path_d - prev_d_r)) begin
            ratio_nxt = RATIO_ONE;
            state_nxt = S_LERP;
          end else begin
            dv_go_nxt = 1'b1;
            state_nxt = S_DIV;
          end
        end else if (CW'(idx_r) == cnt_r - 1'b1) begin
          state_nxt = S_DONE;
        end else begin
          q_nxt[0]   = rd_q.x;
          q_nxt[1]   = rd_q.y;
          q_nxt[2]   = rd_q.z;
          prev_d_nxt = rd_q.path_d;
          idx_nxt    = idx_r + 1'b1;
          rd_addr    = idx_r + 1'b1;
        end
      end
      S_DIV: begin
        if (dv_done) begin
          ratio_nxt = {1'b0, dv_quo};
          state_nxt = S_LERP;
        end
      end
      S_LERP: begin
        res_nxt[ax_r] = 32'(q_r[ax_r] + 32'(l_prod >>> 16));
        ax_nxt        = ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          use_res_nxt = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {full_r, cnt_ext[6:0], out_total, o_p[2], o_p[1], o_p[0]};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_ext   = {7'd0, cnt_r};
    out_total = (cnt_r == '0) ? 32'd0 : last_d_r;
    for (int i = 0; i < 3; i++) begin
      o_p[i] = use_res_r ? res_r[i] : base[i];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IW-1:0]] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sq_go_r     <= 1'b0;
      dv_go_r     <= 1'b0;
      start_r     <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sq_go_r     <= sq_go_nxt;
      dv_go_r     <= dv_go_nxt;
      if (cfg_valid && cfg_index < 2'd3) begin
        start_r[cfg_index] <= cfg_data;
      end
    end
    last_r     <= last_nxt;
    last_d_r   <= last_d_nxt;
    p_r        <= p_nxt;
    dx_r       <= dx_nxt;
    ax_r       <= ax_nxt;
    sum_r      <= sum_nxt;
    sat_r      <= sat_nxt;
    target_r   <= target_nxt;
    prev_d_r   <= prev_d_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    idx_r      <= idx_nxt;
    q_r        <= q_nxt;
    c_r        <= c_nxt;
    res_r      <= res_nxt;
    ratio_r    <= ratio_nxt;
    use_res_r  <= use_res_nxt;
    full_r     <= full_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/ppi_checker.sv */
`timescale 1ns / 1ps
module ppi_checker
  import ppi_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[135] |-> out_tdata[134:128] == 7'(MAX_POINTS))
    else $error("dropped append with a store that is not full");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken before the first finished");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind polyline_path_interpolator ppi_checker #(.MAX_POINTS(MAX_POINTS)) u_ppi_checker (.*);

/* bench/ppi_path_checker.sv */
`timescale 1ns / 1ps
module ppi_path_checker
  import ppi_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output int               fail_count,
  output int               pending,
  output int               words_checked,
  output int               interp_words,
  output int               dropped_appends
);

  typedef struct packed {
    logic               full;
    logic [6:0]         count;
    logic [31:0]        total;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } path_result_t;

  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_START_Z = 2'd2;

  logic signed [31:0] start_x, start_y, start_z;
  logic signed [31:0] path_x [MAX_POINTS];
  logic signed [31:0] path_y [MAX_POINTS];
  logic signed [31:0] path_z [MAX_POINTS];
  logic [31:0]        path_dist [MAX_POINTS];
  int                 path_len;
  path_result_t       expected_results [$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] segment_length(
      logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
      logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz);
    logic [64:0] acc;
    logic [63:0] mag [3];
    longint      diff [3];
    longint unsigned root;
    diff[0] = longint'(ax) - longint'(bx);
    diff[1] = longint'(ay) - longint'(by);
    diff[2] = longint'(az) - longint'(bz);
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = diff[i] < 0 ? 64'(-diff[i]) : 64'(diff[i]);
      acc = acc + 65'(mag[i] * mag[i]);
      if (acc[64]) return 32'hFFFF_FFFF;
    end
    root = root_floor(acc[63:0]);
    return root > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : root[31:0];
  endfunction

  function automatic logic signed [31:0] blend(logic signed [31:0] a,
                                               logic signed [31:0] b, longint r);
    longint prod;
    prod = (longint'(b) - longint'(a)) * r;
    return 32'(longint'(a) + (prod >>> 16));
  endfunction

  function automatic path_result_t predict_path(logic [1:0] op, logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz, logic [31:0] pd,
      logic signed [17:0] factor);
    path_result_t res;
    longint unsigned sum;
    longint frac, target, prev_d, cd, num, den, ratio;
    longint unsigned an, ad;
    logic signed [31:0] qx, qy, qz;
    res = '0;
    if (op == OP_APPEND || op == OP_APPEND_DIST) begin
      if (path_len >= MAX_POINTS) begin
        res.full = 1'b1;
      end else begin
        if (op == OP_APPEND) begin
          if (path_len == 0) begin
            pd = segment_length(start_x, start_y, start_z, px, py, pz);
          end else begin
            sum = longint'(path_dist[path_len-1]) +
                  longint'(segment_length(path_x[path_len-1], path_y[path_len-1],
                                          path_z[path_len-1], px, py, pz));
            pd = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
          end
        end
        path_x[path_len] = px;
        path_y[path_len] = py;
        path_z[path_len] = pz;
        path_dist[path_len] = pd;
        path_len++;
      end
    end
    if (path_len == 0) begin
      res.x = start_x;
      res.y = start_y;
      res.z = start_z;
      res.total = '0;
    end else begin
      res.x = path_x[path_len-1];
      res.y = path_y[path_len-1];
      res.z = path_z[path_len-1];
      res.total = path_dist[path_len-1];
    end
    res.count = 7'(path_len);
    if (op == OP_INTERP && path_len != 0) begin
      frac = longint'(factor);
      if (frac < 0) frac = 0;
      if (frac > 65536) frac = 65536;
      target = (longint'(res.total) * frac) >>> 16;
      prev_d = 0;
      qx = start_x;
      qy = start_y;
      qz = start_z;
      for (int i = 0; i < path_len; i++) begin
        cd = longint'(path_dist[i]);
        if (target <= cd) begin
          num = target - prev_d;
          den = cd - prev_d;
          if (den == 0 || num == 0 || ((num < 0) != (den < 0))) begin
            ratio = 0;
          end else begin
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            ratio = an >= ad ? 65536 : longint'((an << 16) / ad);
          end
          res.x = blend(qx, path_x[i], ratio);
          res.y = blend(qy, path_y[i], ratio);
          res.z = blend(qz, path_z[i], ratio);
          break;
        end
        qx = path_x[i];
        qy = path_y[i];
        qz = path_z[i];
        prev_d = cd;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    path_result_t got, want;
    if (!rst_n) begin
      start_x <= '0;
      start_y <= '0;
      start_z <= '0;
      path_len = 0;
      expected_results.delete();
      pending <= 0;
      fail_count <= 0;
      words_checked <= 0;
      interp_words <= 0;
      dropped_appends <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_X: start_x <= cfg_data;
          CFG_START_Y: start_y <= cfg_data;
          CFG_START_Z: start_z <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = predict_path(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64],
                            in_tdata[127:96], in_tdata[145:128]);
        expected_results = {expected_results, want};
        if (in_tuser == OP_INTERP) interp_words <= interp_words + 1;
        if (want.full) dropped_appends <= dropped_appends + 1;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        words_checked <= words_checked + 1;
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result word %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("Mismatch at %0t: x %h/%h y %h/%h z %h/%h (expected/actual)",
                       $realtime, want.x, got.x, want.y, got.y, want.z, got.z);
              $display("  total %h/%h count %0d/%0d full %b/%b", want.total, got.total,
                       want.count, got.count, want.full, got.full);
            end
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

/* bench/tb_polyline_path_interpolator.sv */
`timescale 1ns / 1ps
module tb_polyline_path_interpolator
  import ppi_pkg::*;
();

  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_START_Z = 2'd2;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid, in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic [1:0]       in_tuser;
  logic             out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid, cfg_ready;
  logic [1:0]       cfg_index;
  logic [31:0]      cfg_data;
  int               fail_count, pending, words_checked, interp_words, dropped_appends;
  int               idle_cycles;
  logic             hold_output;

  polyline_path_interpolator dut (.*);

  ppi_path_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return 32'($signed($urandom_range(2097152)) - 1048576);
    if (roll < 85) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [17:0] pick_factor();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 18'd0;
    if (roll < 20) return 18'd65536;
    if (roll < 70) return 18'($urandom_range(65536));
    return 18'($urandom);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("polyline_path_interpolator regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_output = 1'b0;
      end else if ($urandom_range(99) < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [31:0] pd, logic [17:0] factor);
    int gap;
    in_tuser <= op;
    in_tdata <= {6'd0, factor, pd, pz, py, px};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_start(logic [1:0] index, logic [31:0] value);
    cfg_index <= index;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic send_random();
    int roll;
    logic [1:0] op;
    roll = $urandom_range(99);
    op = roll < 25 ? OP_APPEND : roll < 40 ? OP_APPEND_DIST : roll < 95 ? OP_INTERP : OP_IDLE;
    send_word(op, pick_coord(), pick_coord(), pick_coord(),
              $urandom_range(3) == 0 ? 32'($urandom) : 32'($urandom_range(1 << 26)),
              pick_factor());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_APPEND;
    cfg_valid = 1'b0;
    cfg_index = REG_START_X;
    cfg_data = '0;
    hold_output = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    send_word(OP_INTERP, '0, '0, '0, '0, 18'd32768);
    send_word(OP_IDLE, '0, '0, '0, '0, '0);
    drain();
    write_start(REG_START_X, 32'h8000_0000);
    write_start(REG_START_Y, 32'h7FFF_FFFF);
    write_start(REG_START_Z, 32'h0001_0000);
    send_word(OP_INTERP, '0, '0, '0, '0, 18'h3FFFF);
    send_word(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '0, '0);
    send_word(OP_INTERP, '0, '0, '0, '0, 18'd65536);
    send_word(OP_APPEND_DIST, 32'h0003_0000, 32'h0004_0000, '0, 32'h0000_1000, '0);
    send_word(OP_APPEND, 32'h0003_0000, 32'h0004_0000, '0, '0, '0);
    send_word(OP_APPEND, 32'h0006_0000, 32'h0008_0000, '0, '0, '0);
    send_word(OP_APPEND_DIST, 32'h0010_0000, 32'hFFF0_0000, 32'h0001_0000, 32'h0000_0800, '0);
    send_word(OP_APPEND_DIST, '0, '0, '0, 32'hFFFF_FFFF, '0);
    send_word(OP_APPEND, 32'h0000_0001, '0, '0, '0, '0);
    send_word(OP_INTERP, '0, '0, '0, '0, 18'd0);
    send_word(OP_INTERP, '0, '0, '0, '0, 18'h20000);
    send_word(OP_INTERP, '0, '0, '0, '0, 18'h1FFFF);
    send_word(OP_INTERP, '0, '0, '0, '0, 18'd1);
    send_word(OP_INTERP, '0, '0, '0, '0, 18'd65535);
    send_word(OP_INTERP, '0, '0, '0, '0, 18'd16384);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_start(REG_START_X, phase == 0 ? 32'h7FFF_FFFF : pick_coord());
      write_start(REG_START_Y, phase == 0 ? 32'h8000_0000 : pick_coord());
      write_start(REG_START_Z, phase == 1 ? '0 : pick_coord());
      for (int n = 0; n < 145; n++) begin
        if (phase == 1 && n == 20) hold_output = 1'b1;
        send_random();
      end
      drain();
    end

    $display("Checked %0d result words: %0d interpolations, %0d appends dropped on a full path.",
             words_checked, interp_words, dropped_appends);
    if (fail_count == 0) begin
      $display("polyline_path_interpolator regression: pass");
    end else begin
      $display("polyline_path_interpolator regression: fail");
    end
    $finish;
  end

endmodule

/* polyline_path_interpolator.f */
design/ppi_pkg.sv
design/ppi_isqrt.sv
design/ppi_div.sv
design/polyline_path_interpolator.sv
design/ppi_checker.sv
bench/ppi_path_checker.sv
bench/tb_polyline_path_interpolator.sv
